// ===== src/sdfp_pkg.sv =====
package sdfp_pkg;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_MANY_DOTS    = 3'd2,
        ST_NO_INT       = 3'd3,
        ST_TRAIL_DOT    = 3'd4,
        ST_TOO_MANY_DEC = 3'd5,
        ST_NON_DIGIT    = 3'd6,
        ST_OVERFLOW     = 3'd7
    } status_t;

    localparam logic       KIND_CHAR = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int         ACCUM_W   = 63;
    localparam int         POW_W     = 60;
    localparam int         FRAC_W    = 6;
    localparam int         PREC_W    = 5;
    localparam int         TDATA_W   = 72;

    // frac_count stops one above the largest precision
    localparam logic [FRAC_W-1:0] FRAC_SAT = 6'd32;
    localparam logic [1:0]        DOT_SAT  = 2'd2;

    typedef struct packed {
        status_t              status;
        logic                 ovf;
        logic [PREC_W-1:0]    pad;
        logic [ACCUM_W-1:0]   accum;
    } s1_t;

    typedef struct packed {
        status_t              status;
        logic                 ovf;
        logic [ACCUM_W-1:0]   accum;
        logic [POW_W-1:0]     pow;
    } s2_t;

    typedef struct packed {
        status_t              status;
        logic                 ovf;
        logic [63:0]          pp_lo;
        logic [59:0]          pp_lh;
        logic [62:0]          pp_hl;
    } s3_t;

    // 10^n, zero where it does not fit in the amount
    function automatic logic [POW_W-1:0] pow10(input logic [PREC_W-1:0] n);
        logic [POW_W-1:0] r;
        unique case (n)
            5'd0:    r = 60'd1;
            5'd1:    r = 60'd10;
            5'd2:    r = 60'd100;
            5'd3:    r = 60'd1000;
            5'd4:    r = 60'd10000;
            5'd5:    r = 60'd100000;
            5'd6:    r = 60'd1000000;
            5'd7:    r = 60'd10000000;
            5'd8:    r = 60'd100000000;
            5'd9:    r = 60'd1000000000;
            5'd10:   r = 60'd10000000000;
            5'd11:   r = 60'd100000000000;
            5'd12:   r = 60'd1000000000000;
            5'd13:   r = 60'd10000000000000;
            5'd14:   r = 60'd100000000000000;
            5'd15:   r = 60'd1000000000000000;
            5'd16:   r = 60'd10000000000000000;
            5'd17:   r = 60'd100000000000000000;
            5'd18:   r = 60'd1000000000000000000;
            default: r = '0;
        endcase
        return r;
    endfunction

    // largest accumulator that survives n zero pushes: floor((2^63-1) / 10^n)
    function automatic logic [ACCUM_W-1:0] amount_limit(input logic [PREC_W-1:0] n);
        logic [ACCUM_W-1:0] r;
        unique case (n)
            5'd0:    r = 63'd9223372036854775807;
            5'd1:    r = 63'd922337203685477580;
            5'd2:    r = 63'd92233720368547758;
            5'd3:    r = 63'd9223372036854775;
            5'd4:    r = 63'd922337203685477;
            5'd5:    r = 63'd92233720368547;
            5'd6:    r = 63'd9223372036854;
            5'd7:    r = 63'd922337203685;
            5'd8:    r = 63'd92233720368;
            5'd9:    r = 63'd9223372036;
            5'd10:   r = 63'd922337203;
            5'd11:   r = 63'd92233720;
            5'd12:   r = 63'd9223372;
            5'd13:   r = 63'd922337;
            5'd14:   r = 63'd92233;
            5'd15:   r = 63'd9223;
            5'd16:   r = 63'd922;
            5'd17:   r = 63'd92;
            5'd18:   r = 63'd9;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/strict_decimal_to_fixed_point.sv =====
// Strict decimal parser: a token arrives one byte per transaction on the slave stream
// (tuser low = character, tuser high = end of token) and must read digits, optionally
// followed by '.' and 1..precision digits. Each character updates the running value
// (times ten plus digit) in the cycle it is taken, so one transaction is accepted per
// clock whenever the result path is not backed up. The end transaction produces one
// result, status plus amount scaled by 10^precision, through registers s1, s2, s3 and
// the output register; zero padding of missing fraction digits is a 63 x 60 bit
// multiply split into 32-bit partial products. Token state clears after
// every end transaction. The precision register (reset 8) may be written only while
// no token is in flight; writes are always taken.
module strict_decimal_to_fixed_point
    import sdfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [PREC_W-1:0]    cfg_data,        // precision

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,    // [7:0] ch
    input  logic                 s_axis_tuser,    // [0] kind

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata     // [2:0] status, [65:3] amount, rest zero
);

    logic [PREC_W-1:0]   precision_reg;

    logic [ACCUM_W-1:0]  accum_reg, accum_next;
    logic                overflowed_reg, overflowed_next;
    logic [1:0]          dot_count_reg, dot_count_next;
    logic                int_seen_reg, int_seen_next;
    logic [FRAC_W-1:0]   frac_count_reg, frac_count_next;
    logic                bad_char_reg, bad_char_next;
    logic                any_char_reg, any_char_next;

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    s1_t                 s1_reg, s1_next;
    s2_t                 s2_reg, s2_next;
    s3_t                 s3_reg, s3_next;
    status_t             status_reg, status_next;
    logic [ACCUM_W-1:0]  amount_reg, amount_next;

    logic                s1_ready, s2_ready, s3_ready, out_ready;
    logic                in_acc, end_acc;
    logic                is_digit;
    logic [3:0]          digit;
    logic [66:0]         push_sum;
    logic [63:0]         mid_sum;
    logic [ACCUM_W-1:0]  padded;
    status_t             pre_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            precision_reg <= 5'd8;
        else if (cfg_valid && cfg_ready)
            precision_reg <= cfg_data;
    end

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s3_ready      = !s3_valid_reg || out_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign end_acc = in_acc && (s_axis_tuser == KIND_END);

    assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign digit    = 4'(s_axis_tdata - CH_ZERO);
    assign push_sum = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                    + {63'd0, digit};

    // token state: one character per transaction
    always_comb
    begin
        accum_next      = accum_reg;
        overflowed_next = overflowed_reg;
        dot_count_next  = dot_count_reg;
        int_seen_next   = int_seen_reg;
        frac_count_next = frac_count_reg;
        bad_char_next   = bad_char_reg;
        any_char_next   = any_char_reg;
        if (end_acc)
        begin
            accum_next      = '0;
            overflowed_next = 1'b0;
            dot_count_next  = '0;
            int_seen_next   = 1'b0;
            frac_count_next = '0;
            bad_char_next   = 1'b0;
            any_char_next   = 1'b0;
        end
        else if (in_acc)
        begin
            any_char_next = 1'b1;
            // after a second dot only the seen mark changes
            if (dot_count_reg < DOT_SAT)
            begin
                if (s_axis_tdata == CH_DOT)
                    dot_count_next = dot_count_reg + 2'd1;
                else
                begin
                    if (dot_count_reg == 2'd0)
                        int_seen_next = 1'b1;
                    else if (frac_count_reg < FRAC_SAT)
                        frac_count_next = frac_count_reg + 6'd1;
                    if (!is_digit)
                        bad_char_next = 1'b1;
                    else if (!overflowed_reg)
                    begin
                        if (push_sum[66:63] != 4'd0)
                            overflowed_next = 1'b1;
                        else
                            accum_next = push_sum[62:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg      <= '0;
            overflowed_reg <= 1'b0;
            dot_count_reg  <= '0;
            int_seen_reg   <= 1'b0;
            frac_count_reg <= '0;
            bad_char_reg   <= 1'b0;
            any_char_reg   <= 1'b0;
        end
        else
        begin
            accum_reg      <= accum_next;
            overflowed_reg <= overflowed_next;
            dot_count_reg  <= dot_count_next;
            int_seen_reg   <= int_seen_next;
            frac_count_reg <= frac_count_next;
            bad_char_reg   <= bad_char_next;
            any_char_reg   <= any_char_next;
        end
    end

    // format checks in priority order, overflow is decided after padding
    always_comb
    begin
        priority if (!any_char_reg)
            pre_status = ST_EMPTY;
        else if (dot_count_reg >= DOT_SAT)
            pre_status = ST_MANY_DOTS;
        else if (!int_seen_reg)
            pre_status = ST_NO_INT;
        else if (dot_count_reg == 2'd1 && frac_count_reg == '0)
            pre_status = ST_TRAIL_DOT;
        else if (frac_count_reg > {1'b0, precision_reg})
            pre_status = ST_TOO_MANY_DEC;
        else if (bad_char_reg)
            pre_status = ST_NON_DIGIT;
        else
            pre_status = ST_OK;
    end

    always_comb
    begin
        s1_next.status = pre_status;
        s1_next.ovf    = overflowed_reg;
        s1_next.pad    = precision_reg - frac_count_reg[PREC_W-1:0];
        s1_next.accum  = accum_reg;

        s2_next.status = s1_reg.status;
        s2_next.ovf    = s1_reg.ovf || (s1_reg.accum > amount_limit(s1_reg.pad));
        s2_next.accum  = s1_reg.accum;
        s2_next.pow    = pow10(s1_reg.pad);

        s3_next.status = s2_reg.status;
        s3_next.ovf    = s2_reg.ovf;
        s3_next.pp_lo  = s2_reg.accum[31:0] * s2_reg.pow[31:0];
        s3_next.pp_lh  = s2_reg.accum[31:0] * s2_reg.pow[59:32];
        s3_next.pp_hl  = s2_reg.accum[62:32] * s2_reg.pow[31:0];
    end

    // only the low 63 bits of the product matter once overflow is ruled out
    assign mid_sum = {4'd0, s3_reg.pp_lh} + {1'b0, s3_reg.pp_hl};
    assign padded  = s3_reg.pp_lo[62:0] + {mid_sum[30:0], 32'd0};

    always_comb
    begin
        if (s3_reg.status != ST_OK)
            status_next = s3_reg.status;
        else if (s3_reg.ovf)
            status_next = ST_OVERFLOW;
        else
            status_next = ST_OK;
        amount_next = (status_next == ST_OK) ? padded : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= end_acc;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
            s1_reg <= s1_next;
        if (s2_ready)
            s2_reg <= s2_next;
        if (s3_ready)
            s3_reg <= s3_next;
        if (out_ready)
        begin
            status_reg <= status_next;
            amount_reg <= amount_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, amount_reg, status_reg};

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        end_acc |=> (accum_reg == '0 && !any_char_reg && !overflowed_reg))
        else $error("token state not cleared after end transaction");

    a_frac_needs_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (frac_count_reg != '0) |-> (dot_count_reg != 2'd0))
        else $error("fraction digits counted without a dot");

    a_accum_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (overflowed_reg && !end_acc) |=> $stable(accum_reg))
        else $error("accumulator moved after overflow");

    a_amount_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (amount_reg == '0))
        else $error("nonzero amount with error status");

endmodule

// ===== sim/sdfp_checker.sv =====
`timescale 1ns / 100ps

module sdfp_checker
    import sdfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [PREC_W-1:0]    cfg_data,

    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,    // [7:0] ch
    input  logic                 s_axis_tuser,    // [0] kind

    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [TDATA_W-1:0]   m_axis_tdata,    // [2:0] status, [65:3] amount, rest zero

    output int                   mismatches,
    output int                   pending
);

    localparam longint unsigned AMOUNT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        status_t            status;
        logic [ACCUM_W-1:0] amount;
    } parse_result_t;

    parse_result_t     expected_results[$];
    int                fail_count     = 0;
    int                queued         = 0;

    logic [PREC_W-1:0] precision      = 5'd8;
    longint unsigned   value_acc      = 0;
    bit                value_ovf      = 1'b0;
    int unsigned       dots_seen      = 0;
    bit                int_part_seen  = 1'b0;
    int unsigned       frac_digits    = 0;
    bit                non_digit_seen = 1'b0;
    bit                char_seen      = 1'b0;

    assign mismatches = fail_count;
    assign pending    = queued;

    function automatic void clear_token();
        value_acc      = 0;
        value_ovf      = 1'b0;
        dots_seen      = 0;
        int_part_seen  = 1'b0;
        frac_digits    = 0;
        non_digit_seen = 1'b0;
        char_seen      = 1'b0;
    endfunction

    // freeze the value once a push would pass 2^63-1
    function automatic void shift_digit(input int unsigned d);
        if (value_ovf)
            return;
        if (value_acc > (AMOUNT_MAX - d) / 10)
            value_ovf = 1'b1;
        else
            value_acc = value_acc * 10 + d;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        char_seen = 1'b1;
        if (dots_seen >= 2)
            return;
        if (c == CH_DOT)
        begin
            dots_seen++;
            return;
        end
        if (dots_seen == 0)
            int_part_seen = 1'b1;
        else if (frac_digits < FRAC_SAT)
            frac_digits++;
        if (c >= CH_ZERO && c <= CH_NINE)
            shift_digit(c - CH_ZERO);
        else
            non_digit_seen = 1'b1;
    endfunction

    function automatic parse_result_t close_token();
        parse_result_t r;
        int unsigned   pad;
        r.amount = '0;
        if (!char_seen)
            r.status = ST_EMPTY;
        else if (dots_seen >= 2)
            r.status = ST_MANY_DOTS;
        else if (!int_part_seen)
            r.status = ST_NO_INT;
        else if (dots_seen == 1 && frac_digits == 0)
            r.status = ST_TRAIL_DOT;
        else if (frac_digits > precision)
            r.status = ST_TOO_MANY_DEC;
        else if (non_digit_seen)
            r.status = ST_NON_DIGIT;
        else
        begin
            // pad the missing fraction digits with zeros
            for (pad = precision - frac_digits; pad > 0; pad--)
                shift_digit(0);
            if (value_ovf)
                r.status = ST_OVERFLOW;
            else
            begin
                r.status = ST_OK;
                r.amount = value_acc[ACCUM_W-1:0];
            end
        end
        clear_token();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        parse_result_t exp_r;
        if (!rst_n)
        begin
            precision = 5'd8;
            clear_token();
            expected_results.delete();
            queued <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual status %0d amount %0d",
                             $time, m_axis_tdata[2:0], m_axis_tdata[65:3]);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_axis_tdata[2:0] !== exp_r.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                                 exp_r.status, m_axis_tdata[2:0]);
                    end
                    if (m_axis_tdata[65:3] !== exp_r.amount)
                    begin
                        fail_count++;
                        $display("%0t: amount mismatch: expected %0d, actual %0d", $time,
                                 exp_r.amount, m_axis_tdata[65:3]);
                    end
                    if (m_axis_tdata[TDATA_W-1:66] !== '0)
                    begin
                        fail_count++;
                        $display("%0t: fill bits mismatch: expected 0, actual %0h", $time,
                                 m_axis_tdata[TDATA_W-1:66]);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
                precision = cfg_data;

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == KIND_END)
                    expected_results.push_back(close_token());
                else
                    take_char(s_axis_tdata);
            end

            queued <= expected_results.size();
        end
    end

endmodule

// ===== sim/strict_decimal_to_fixed_point_tb.sv =====
`timescale 1ns / 100ps

module strict_decimal_to_fixed_point_tb;
    import sdfp_pkg::*;

    localparam longint unsigned AMOUNT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int              PHASE_ITEMS = 180;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
    typedef enum int {MUT_BYTE, MUT_DOT, MUT_NO_INT, MUT_TRAIL_DOT, MUT_AFTER_DOTS} mutation_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [PREC_W-1:0]   cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;
    logic                s_axis_tuser  = KIND_CHAR;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    int                  mismatches;
    int                  pending;

    logic [7:0]          token_text[$];
    int                  burst_left    = 0;
    int                  items_sent    = 0;
    logic [PREC_W-1:0]   cur_prec      = 5'd8;
    rx_mode_t            stall_mode    = RX_OPEN;
    int                  stall_left    = 0;
    int                  stall_phase   = 0;

    strict_decimal_to_fixed_point u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sdfp_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver backpressure: switch between stall patterns every so often
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= (stall_phase % 5) < 2;
        endcase
    end

    task automatic send_item(input logic kind, input logic [7:0] ch);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        items_sent++;
    endtask

    // byte of an end transaction is random: the block must ignore it
    task automatic send_token();
        foreach (token_text[i])
            send_item(KIND_CHAR, token_text[i]);
        send_item(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string s);
        token_text.delete();
        for (int i = 0; i < s.len(); i++)
            token_text.push_back(s[i]);
        send_token();
    endtask

    // hold off until every result is back, then let the pipeline settle
    task automatic drain(input int extra);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_precision(input logic [PREC_W-1:0] p);
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_prec = p;
    endtask

    task automatic add_digits(input int n);
        repeat (n) token_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic add_noise(input int n);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0:       token_text.push_back(CH_DOT);
                1:       token_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                default: token_text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic add_value(input longint unsigned v);
        logic [7:0] digs[$];
        do
        begin
            digs.push_front(8'(CH_ZERO + v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digs[i])
            token_text.push_back(digs[i]);
    endtask

    task automatic make_well_formed(input int prec);
        int n_int;
        int n_frac;
        n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        add_digits(n_int);
        if ($urandom_range(0, 3) != 0)
        begin
            token_text.push_back(CH_DOT);
            if (prec == 0 || $urandom_range(0, 9) == 0)
                n_frac = prec + $urandom_range(1, 3);
            else if ($urandom_range(0, 1) == 0)
                n_frac = $urandom_range(1, (prec < 4) ? prec : 4);
            else
                n_frac = $urandom_range(1, prec);
            add_digits(n_frac);
        end
    endtask

    // integer part right around the largest value that survives the padding
    task automatic make_boundary(input int prec);
        longint unsigned p10;
        if (prec > 18)
        begin
            make_well_formed(prec);
            return;
        end
        p10 = 1;
        repeat (prec) p10 = p10 * 10;
        add_value(AMOUNT_MAX / p10 + $urandom_range(0, 2) - 1);
        if (prec > 0 && $urandom_range(0, 1) == 0)
        begin
            token_text.push_back(CH_DOT);
            add_digits($urandom_range(1, prec));
        end
    endtask

    task automatic make_broken(input int prec);
        int pos;
        make_well_formed(prec);
        pos = $urandom_range(0, token_text.size());
        case (mutation_t'($urandom_range(0, 4)))
            MUT_BYTE:      token_text.insert(pos, 8'($urandom_range(0, 255)));
            MUT_DOT:       token_text.insert(pos, CH_DOT);
            MUT_NO_INT:
            begin
                while (token_text.size() != 0 && token_text[0] != CH_DOT)
                    token_text.delete(0);
                if (token_text.size() == 0)
                begin
                    token_text.push_back(CH_DOT);
                    add_digits(1);
                end
            end
            MUT_TRAIL_DOT: token_text.push_back(CH_DOT);
            default:
            begin
                token_text.push_back(CH_DOT);
                token_text.push_back(CH_DOT);
                add_noise($urandom_range(1, 4));
            end
        endcase
    endtask

    initial
    begin
        int sel;
        int phase_start;
        int phase_prec[8];
        phase_prec    = '{0, 18, 31, 19, 1, 0, 0, 8};
        phase_prec[5] = $urandom_range(2, 17);
        phase_prec[6] = $urandom_range(20, 30);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("");
        send_text("0");
        send_text("1..9");
        send_text(".5");
        send_text("7.");
        send_text("1x");
        drain(8);
        write_precision(5'd1);
        send_text("2.25");
        drain(8);
        write_precision(5'd31);
        send_text("1");

        foreach (phase_prec[p])
        begin
            drain(8);
            write_precision(PREC_W'(phase_prec[p]));
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                token_text.delete();
                if (sel < 55)
                    make_well_formed(int'(cur_prec));
                else if (sel < 65)
                    make_boundary(int'(cur_prec));
                else if (sel < 88)
                    make_broken(int'(cur_prec));
                else
                    add_noise($urandom_range(0, 8));
                send_token();
            end
        end

        drain(20);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
